// ===== hdl/rxst_pkg.sv =====
// Package for the range XOR segment tree.
// Holds the field widths, payload types and opcode names shared by all files.
// No dependencies.
package rxst_pkg;

  localparam int unsigned LEAVES_DEF = 1024;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned DATA_W = 32;

  typedef logic [OP_W-1:0]   opcode_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam opcode_t OP_WRITE = 2'd0;
  localparam opcode_t OP_QUERY = 2'd1;
  localparam opcode_t OP_SWAP  = 2'd2;

endpackage

// ===== hdl/rxst_if.sv =====
// Valid/ready channel interfaces for the range XOR segment tree.
// rxst_req_if carries command items, rxst_rsp_if carries query results.
// Depends on rxst_pkg.
interface rxst_req_if import rxst_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  pos_t    first_pos;
  pos_t    second_pos;
  word_t   leaf_value;

  modport source (output valid, output opcode, output first_pos, output second_pos,
                  output leaf_value, input ready);
  modport sink   (input valid, input opcode, input first_pos, input second_pos,
                  input leaf_value, output ready);
endinterface

interface rxst_rsp_if import rxst_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t xor_result;

  modport source (output valid, output xor_result, input ready);
  modport sink   (input valid, input xor_result, output ready);
endinterface

// ===== hdl/rxst_ram.sv =====
// Node memory for the range XOR segment tree: one write port, one read port,
// registered read data. Depends on rxst_pkg.
module rxst_ram import rxst_pkg::*; #(
  parameter int unsigned DEPTH  = 2 * LEAVES_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  word_t             wdata,
  input  logic [ADDR_W-1:0] raddr,
  output word_t             rdata
);

  word_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/range_xor_segment_tree.sv =====
// Range XOR segment tree: 2*LEAVES node words in one synchronous RAM (heap layout).
// A query's result is valid as the block goes idle.
// Throughput: one item at a time, set by the single RAM read port walking tree levels.
// Reset: synchronous; a clearing pass zeroes the RAM, no item accepted.
// Depends on rxst_pkg, rxst_if, rxst_ram.
module range_xor_segment_tree import rxst_pkg::*; #(
  parameter int unsigned LEAVES = LEAVES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rxst_req_if.sink   req,
  rxst_rsp_if.source rsp
);

  localparam int unsigned NODES  = 2 * LEAVES;
  localparam int unsigned NODE_W = $clog2(NODES);
  localparam int unsigned CNT_W  = NODE_W + 1;
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  localparam cmp_t  LEAVES_C = CMP_W'(LEAVES);
  localparam cmp_t  ONE_C    = CMP_W'(1);
  localparam node_t ROOT     = NODE_W'(1);
  localparam node_t LAST     = NODE_W'(NODES - 1);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SW_A  = 4'd2;
  localparam logic [3:0] ST_SW_B  = 4'd3;
  localparam logic [3:0] ST_SW_C  = 4'd4;
  localparam logic [3:0] ST_LEAF  = 4'd5;
  localparam logic [3:0] ST_UP    = 4'd6;
  localparam logic [3:0] ST_QL    = 4'd7;
  localparam logic [3:0] ST_QR    = 4'd8;

  logic [3:0] state;
  node_t      clr_idx;
  node_t      node;
  node_t      node_b;
  word_t      cur;
  word_t      val_b;
  logic       second;
  cnt_t       q_l;
  cnt_t       q_r;
  word_t      acc;
  logic       rd_pend;
  logic       rsp_valid;
  word_t      rsp_data;

  logic  mem_we;
  node_t waddr;
  word_t wdata;
  node_t raddr;
  word_t mem_rdata;
  logic  rd_issue;
  logic  q_issue;

  cmp_t  p1, p2, c1, c2, qa, qb;
  logic  p1_ok, p2_ok, accept, q_live, rsp_free;
  node_t ka, kb;
  cnt_t  l_init, r_init, r_dec;
  word_t up_val, acc_next;

  rxst_ram #(.DEPTH(NODES), .ADDR_W(NODE_W)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (mem_rdata)
  );

  // Decode positions: validity, saturation, ordering, node indexes
  always_comb begin
    p1     = CMP_W'(req.first_pos);
    p2     = CMP_W'(req.second_pos);
    p1_ok  = (p1 != '0) && (p1 <= LEAVES_C);
    p2_ok  = (p2 != '0) && (p2 <= LEAVES_C);
    c1     = (p1 == '0) ? ONE_C : ((p1 > LEAVES_C) ? LEAVES_C : p1);
    c2     = (p2 == '0) ? ONE_C : ((p2 > LEAVES_C) ? LEAVES_C : p2);
    qa     = (c1 <= c2) ? c1 : c2;
    qb     = (c1 <= c2) ? c2 : c1;
    ka     = NODE_W'(LEAVES_C + p1 - ONE_C);
    kb     = NODE_W'(LEAVES_C + p2 - ONE_C);
    l_init = CNT_W'(LEAVES_C + qa - ONE_C);
    r_init = CNT_W'(LEAVES_C + qb);
  end

  assign accept   = req.valid && req.ready;
  assign q_live   = q_l < q_r;
  assign r_dec    = q_r - CNT_W'(1);
  assign up_val   = cur ^ mem_rdata;
  assign acc_next = rd_pend ? (acc ^ mem_rdata) : acc;
  assign rsp_free = !rsp_valid || rsp.ready;

  // Drive the RAM ports from the sequencer state
  always_comb begin
    mem_we   = 1'b0;
    waddr    = node;
    wdata    = cur;
    raddr    = '0;
    rd_issue = 1'b0;
    q_issue  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_idx;
        wdata  = '0;
      end
      ST_SW_A: begin
        raddr    = node;
        rd_issue = 1'b1;
      end
      ST_SW_B: begin
        raddr    = node_b;
        rd_issue = 1'b1;
      end
      ST_LEAF: begin
        mem_we   = 1'b1;
        raddr    = node ^ ROOT;
        rd_issue = 1'b1;
      end
      ST_UP: begin
        mem_we   = 1'b1;
        wdata    = up_val;
        raddr    = node ^ ROOT;
        rd_issue = (node != ROOT);
      end
      ST_QL: begin
        raddr    = q_l[NODE_W-1:0];
        rd_issue = q_live && q_l[0];
        q_issue  = rd_issue;
      end
      ST_QR: begin
        raddr    = r_dec[NODE_W-1:0];
        rd_issue = q_r[0];
        q_issue  = rd_issue;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer: clear, accept, swap reads, root walks, range walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      second  <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= q_issue;
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + NODE_W'(1);
          if (clr_idx == LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            priority if (req.opcode == OP_WRITE && p1_ok) begin
              node   <= ka;
              cur    <= req.leaf_value;
              second <= 1'b0;
              state  <= ST_LEAF;
            end else if (req.opcode == OP_QUERY) begin
              q_l   <= l_init;
              q_r   <= r_init;
              acc   <= '0;
              state <= ST_QL;
            end else if (req.opcode == OP_SWAP && p1_ok && p2_ok && (p1 != p2)) begin
              node   <= ka;
              node_b <= kb;
              state  <= ST_SW_A;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_SW_A: begin
          state <= ST_SW_B;
        end
        ST_SW_B: begin
          // first leaf value arrives
          val_b <= mem_rdata;
          state <= ST_SW_C;
        end
        ST_SW_C: begin
          // second leaf value goes to the first position
          cur    <= mem_rdata;
          second <= 1'b1;
          state  <= ST_LEAF;
        end
        ST_LEAF: begin
          node  <= node >> 1;
          state <= ST_UP;
        end
        ST_UP: begin
          cur <= up_val;
          if (node != ROOT) begin
            node <= node >> 1;
          end else if (second) begin
            second <= 1'b0;
            node   <= node_b;
            cur    <= val_b;
            state  <= ST_LEAF;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_QL: begin
          acc <= acc_next;
          if (q_live) begin
            if (q_l[0]) begin
              q_l <= q_l + CNT_W'(1);
            end
            state <= ST_QR;
          end else if (rsp_free) begin
            state <= ST_IDLE;
          end
        end
        ST_QR: begin
          acc   <= acc_next;
          q_l   <= q_l >> 1;
          q_r   <= q_r >> 1;
          state <= ST_QL;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: load a finished query, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_QL && !q_live && rsp_free) begin
      rsp_valid <= 1'b1;
      rsp_data  <= acc_next;
    end else if (rsp_valid && rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.xor_result = rsp_data;

  // The walks never read the entry they write in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && rd_issue) |-> (waddr != raddr))
    else $error("RAM read and write hit the same node");

  // A result appears only at the end of a range walk
  a_rsp_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_QL))
    else $error("result raised outside a query");

  // Range bounds never cross during a walk
  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QL || state == ST_QR) |-> (q_l <= q_r))
    else $error("query bounds crossed");

  // Node zero is unused after the clearing pass
  a_no_node_zero: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != ST_CLEAR) |-> (waddr != '0))
    else $error("walk wrote node zero");

endmodule
